// ===== sv/scfp_pkg.sv =====
// ----------------------------------------------------------------------------
// scfp_pkg
// Shared types and constants for the checksummed frame parser.
// ----------------------------------------------------------------------------
package scfp_pkg;

    localparam int unsigned MAX_FRAME_LEN_DEF = 255;
    localparam int unsigned MIN_FRAME_LEN     = 18;
    localparam int unsigned PAYLOAD_START     = 4;
    localparam int unsigned PAYLOAD_DEPTH     = 14;
    localparam int unsigned NUM_VALUES        = 7;
    localparam int unsigned CFG_IDX_W         = 3;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_FIRST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_SECOND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL_FIRST  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL_SECOND = 3'd3;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_BAD_HEAD = 3'd1,
        ST_BAD_TAIL = 3'd2,
        ST_BAD_SUM = 3'd3,
        ST_SHORT   = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0] head_first;
        logic [7:0] head_second;
        logic [7:0] tail_first;
        logic [7:0] tail_second;
    } frame_cfg_t;

    typedef struct packed {
        status_t                          status;
        logic [NUM_VALUES-1:0][15:0]      values;
        logic [15:0]                      received_sum;
        logic [7:0]                       frame_length;
    } frame_result_t;

endpackage

// ===== sv/scfp_frame_track.sv =====
// ----------------------------------------------------------------------------
// scfp_frame_track
// Per-byte frame state: count, running sum, head, payload and tail window.
// Builds the frame result on the last byte.
// ----------------------------------------------------------------------------
module scfp_frame_track #(
    parameter int unsigned MAX_FRAME_LEN = scfp_pkg::MAX_FRAME_LEN_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  scfp_pkg::frame_cfg_t    cfg,
    input  logic                    byte_fire,
    input  logic [7:0]              data_byte,
    input  logic                    last_byte,
    output logic                    res_valid,
    output scfp_pkg::frame_result_t res
);
    import scfp_pkg::*;

    logic [7:0]  count_reg, count_next;
    logic [15:0] sum_reg, sum_next;
    logic [1:0][7:0] head_reg, head_next;
    logic [3:0][7:0] win_reg, win_next;
    logic [PAYLOAD_DEPTH-1:0][7:0] pay_reg, pay_next;
    logic [15:0] rx_sum;
    status_t     status;

    always_comb begin
        head_next = head_reg;
        pay_next  = pay_reg;
        if (count_reg < 8'd2) begin
            head_next[count_reg[0]] = data_byte;
        end
        for (int i = 0; i < PAYLOAD_DEPTH; i++) begin
            if (count_reg == 8'(PAYLOAD_START + i)) begin
                pay_next[i] = data_byte;
            end
        end
        // byte leaving the window joins the sum
        if (count_reg >= 8'(PAYLOAD_START)) begin
            sum_next = sum_reg + {8'd0, win_reg[0]};
        end else begin
            sum_next = sum_reg;
        end
        win_next = {data_byte, win_reg[3], win_reg[2], win_reg[1]};
        if (count_reg < 8'(MAX_FRAME_LEN)) begin
            count_next = count_reg + 8'd1;
        end else begin
            count_next = count_reg;
        end
    end

    always_comb begin
        rx_sum = 16'd0;
        if (count_next < 8'(MIN_FRAME_LEN)) begin
            status = ST_SHORT;
        end else begin
            rx_sum = {win_next[1], win_next[0]};
            if (head_next[0] != cfg.head_first || head_next[1] != cfg.head_second) begin
                status = ST_BAD_HEAD;
            end else if (win_next[2] != cfg.tail_first ||
                         win_next[3] != cfg.tail_second) begin
                status = ST_BAD_TAIL;
            end else if (rx_sum != sum_next) begin
                status = ST_BAD_SUM;
            end else begin
                status = ST_OK;
            end
        end
        res.status       = status;
        res.frame_length = count_next;
        res.received_sum = rx_sum;
        for (int k = 0; k < NUM_VALUES; k++) begin
            res.values[k] = (status == ST_OK) ? {pay_next[2*k+1], pay_next[2*k]} : 16'd0;
        end
    end

    assign res_valid = byte_fire & last_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            sum_reg   <= '0;
            head_reg  <= '0;
            win_reg   <= '0;
            pay_reg   <= '0;
        end else if (byte_fire) begin
            head_reg <= head_next;
            win_reg  <= win_next;
            pay_reg  <= pay_next;
            // clear the frame counters after the last byte
            if (last_byte) begin
                count_reg <= '0;
                sum_reg   <= '0;
            end else begin
                count_reg <= count_next;
                sum_reg   <= sum_next;
            end
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 8'(MAX_FRAME_LEN))
        else $error("byte count beyond maximum frame length");

    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_fire && last_byte |=> count_reg == 8'd0 && sum_reg == 16'd0)
        else $error("frame counters not cleared after last byte");

    a_count_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_fire && !last_byte |=> count_reg != 8'd0)
        else $error("byte count did not advance");

    a_short_no_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.status == ST_SHORT |-> res.received_sum == 16'd0 &&
        res.frame_length < 8'(MIN_FRAME_LEN))
        else $error("short frame reported with checksum or long length");

endmodule

// ===== sv/scfp_out_reg.sv =====
// ----------------------------------------------------------------------------
// scfp_out_reg
// Result register: holds one frame result until the sink takes it.
// ----------------------------------------------------------------------------
module scfp_out_reg (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    input  scfp_pkg::frame_result_t in_res,
    output logic                    in_ready,
    output logic                    out_valid,
    input  logic                    out_ready,
    output scfp_pkg::frame_result_t out_res
);
    import scfp_pkg::*;

    logic          valid_reg;
    frame_result_t res_reg;

    // space when empty or when the held result leaves this cycle
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_valid && in_ready) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            res_reg <= in_res;
        end
    end

endmodule

// ===== sv/sum_checked_frame_parser.sv =====
// ----------------------------------------------------------------------------
// sum_checked_frame_parser
// Byte-serial frame checker: head, tail and 16-bit additive checksum,
// with seven little-endian int16 values taken from bytes 4..17.
// ----------------------------------------------------------------------------
//  channel   dir   handshake             content
//  s_*       in    s_tvalid / s_tready   tdata[7:0] data_byte, tlast last_byte
//  m_*       out   m_tvalid / m_tready   tuser status, tdata length/sum/values
//  cfg_*     in    cfg_valid / cfg_ready register index and 8-bit value
//
//  One byte is taken every cycle while s_tready is high; a result is valid in
//  the cycle after the last byte of its frame, held in the single result register.
//  s_tready drops only while a result is held and m_tready is low.
//  aresetn is synchronous, active low; it clears the configuration, frame state and result valid flag.
//  cfg_ready is always high; writes take effect on the next cycle.
// ----------------------------------------------------------------------------
module sum_checked_frame_parser #(
    parameter int unsigned MAX_FRAME_LEN = scfp_pkg::MAX_FRAME_LEN_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] data_byte
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [135:0]                   m_tdata,   // frame_length, received_sum,
                                                      // front_left_speed, front_right_speed,
                                                      // back_left_speed, back_right_speed,
                                                      // yaw_raw, pitch_raw, roll_raw
    output logic [2:0]                     m_tuser,   // [2:0] status
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [scfp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data
);
    import scfp_pkg::*;

    frame_cfg_t    cfg_reg;
    frame_result_t res, out_res;
    logic          res_valid;
    logic          byte_fire;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_HEAD_FIRST:  cfg_reg.head_first  <= cfg_data;
                CFG_HEAD_SECOND: cfg_reg.head_second <= cfg_data;
                CFG_TAIL_FIRST:  cfg_reg.tail_first  <= cfg_data;
                CFG_TAIL_SECOND: cfg_reg.tail_second <= cfg_data;
                default: ;
            endcase
        end
    end

    assign byte_fire = s_tvalid && s_tready;

    scfp_frame_track #(
        .MAX_FRAME_LEN (MAX_FRAME_LEN)
    ) u_track (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .byte_fire (byte_fire),
        .data_byte (s_tdata),
        .last_byte (s_tlast),
        .res_valid (res_valid),
        .res       (res)
    );

    scfp_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_res    (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tuser = out_res.status;
    assign m_tdata = {out_res.values, out_res.received_sum, out_res.frame_length};

endmodule

// ===== dv/frame_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_result_checker
// Watches the byte, result and register channels of the frame parser, keeps
// its own copy of the frame state and compares every result transaction,
// field by field, with the oldest frame report still due.
// ----------------------------------------------------------------------------
module frame_result_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] data_byte
    input  logic                           s_tlast,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [135:0]                   m_tdata,   // [7:0] frame_length,
                                                      // [23:8] received_sum, then
                                                      // seven int16 values from bit 24 up
    input  logic [2:0]                     m_tuser,   // [2:0] status
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [scfp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data,
    output int                             mismatches,
    output int                             frames_pending
);
    import scfp_pkg::*;

    localparam int unsigned FRAME_CAP = MAX_FRAME_LEN_DEF;

    typedef struct packed {
        status_t                     status;
        logic [NUM_VALUES-1:0][15:0] value;
        logic [15:0]                 rx_sum;
        logic [7:0]                  length;
    } frame_report_t;

    logic [7:0]    want_head_first;
    logic [7:0]    want_head_second;
    logic [7:0]    want_tail_first;
    logic [7:0]    want_tail_second;
    int unsigned   count_in_frame;
    logic [15:0]   sum_acc;
    logic [7:0]    head_seen [2];
    logic [7:0]    last_four [4];
    logic [7:0]    body [PAYLOAD_DEPTH];
    frame_report_t reports_due [$];
    frame_report_t want;
    int            k;

    task automatic flag_error(input string what, input logic [31:0] got,
                              input logic [31:0] exp_val);
        $display("ERROR at %0t: %s got %0h, wanted %0h", $realtime, what, got, exp_val);
        mismatches++;
    endtask

    task automatic take_frame_byte(input logic [7:0] b, input logic is_last);
        frame_report_t r;
        int unsigned   pos;
        int unsigned   j;
        pos = count_in_frame;
        if (pos < 2)
            head_seen[pos] = b;
        if (pos >= PAYLOAD_START && pos < PAYLOAD_START + PAYLOAD_DEPTH)
            body[pos - PAYLOAD_START] = b;
        // the byte pushed out of the window can no longer be tail or checksum
        if (pos >= 4)
            sum_acc = sum_acc + 16'(last_four[0]);
        last_four[0] = last_four[1];
        last_four[1] = last_four[2];
        last_four[2] = last_four[3];
        last_four[3] = b;
        if (count_in_frame < FRAME_CAP)
            count_in_frame++;
        if (is_last) begin
            r = '0;
            r.length = 8'(count_in_frame);
            if (count_in_frame < MIN_FRAME_LEN) begin
                r.status = ST_SHORT;
            end else begin
                r.rx_sum = {last_four[1], last_four[0]};
                if (head_seen[0] != want_head_first || head_seen[1] != want_head_second)
                    r.status = ST_BAD_HEAD;
                else if (last_four[2] != want_tail_first || last_four[3] != want_tail_second)
                    r.status = ST_BAD_TAIL;
                else if (r.rx_sum != sum_acc)
                    r.status = ST_BAD_SUM;
                else
                    r.status = ST_OK;
            end
            if (r.status == ST_OK) begin
                for (j = 0; j < NUM_VALUES; j++)
                    r.value[j] = {body[2*j+1], body[2*j]};
            end
            reports_due.push_back(r);
            count_in_frame = 0;
            sum_acc        = '0;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            mismatches       = 0;
            want_head_first  = '0;
            want_head_second = '0;
            want_tail_first  = '0;
            want_tail_second = '0;
            count_in_frame   = 0;
            sum_acc          = '0;
            for (k = 0; k < 2; k++)
                head_seen[k] = '0;
            for (k = 0; k < 4; k++)
                last_four[k] = '0;
            for (k = 0; k < PAYLOAD_DEPTH; k++)
                body[k] = '0;
            reports_due.delete();
        end else begin
            if (s_tvalid && s_tready)
                take_frame_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                if (reports_due.size() == 0) begin
                    flag_error("result with no frame due, status", 32'(m_tuser), '0);
                end else begin
                    want = reports_due.pop_front();
                    if (m_tuser != want.status)
                        flag_error("status", 32'(m_tuser), 32'(want.status));
                    if (m_tdata[7:0] != want.length)
                        flag_error("frame_length", 32'(m_tdata[7:0]), 32'(want.length));
                    if (m_tdata[23:8] != want.rx_sum)
                        flag_error("received_sum", 32'(m_tdata[23:8]), 32'(want.rx_sum));
                    for (k = 0; k < NUM_VALUES; k++) begin
                        if (m_tdata[24 + 16*k +: 16] != want.value[k])
                            flag_error($sformatf("value %0d", k),
                                       32'(m_tdata[24 + 16*k +: 16]), 32'(want.value[k]));
                    end
                end
            end
            // a write lands after the byte of the same edge has been taken
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_HEAD_FIRST:  want_head_first  = cfg_data;
                    CFG_HEAD_SECOND: want_head_second = cfg_data;
                    CFG_TAIL_FIRST:  want_tail_first  = cfg_data;
                    CFG_TAIL_SECOND: want_tail_second = cfg_data;
                    default: ;
                endcase
            end
        end
        frames_pending = reports_due.size();
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives frames of bytes into the checksummed frame parser under several
// head and tail settings: well-formed frames with random content, frames
// with broken head, tail or checksum, short, long and random noise frames,
// with random idling on both sides and a long stall at the result side.
// ----------------------------------------------------------------------------
module testbench;
    import scfp_pkg::*;

    localparam int unsigned CYCLE_LIMIT       = 100000;
    localparam int unsigned PHASE_QUOTA       = 130;
    localparam int unsigned LONG_STALL_CYCLES = 300;
    localparam int unsigned DRAIN_CYCLES      = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = 3'd4;
    // byte 4 upwards gives 0xffff, 0x0000, 0x7fff, 0x8000, ...
    localparam logic [7:0][7:0] EXTREME_BYTES =
        {8'h00, 8'h00, 8'hFF, 8'hFF, 8'h80, 8'h00, 8'h7F, 8'hFF};

    typedef enum int {
        FR_GOOD, FR_BAD_HEAD, FR_BAD_TAIL, FR_BAD_SUM, FR_SHORT, FR_NOISE
    } frame_kind_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = '0;
    logic                 s_tlast   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [135:0]         m_tdata;
    logic [2:0]           m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]           cfg_data  = '0;
    int                   mismatches;
    int                   frames_pending;

    logic [7:0]  cur_head_first;
    logic [7:0]  cur_head_second;
    logic [7:0]  cur_tail_first;
    logic [7:0]  cur_tail_second;
    bit          steady        = 1'b0;
    bit          long_stall_go = 1'b0;
    bit          stall_used    = 1'b0;
    int unsigned stall_left    = 0;
    int unsigned items_sent    = 0;
    int unsigned cycle_count   = 0;

    sum_checked_frame_parser u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    frame_result_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .frames_pending (frames_pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // result side: random back-pressure, plus one long hold-off on request
    always @(negedge aclk) begin
        if (long_stall_go && !stall_used) begin
            stall_used <= 1'b1;
            stall_left <= LONG_STALL_CYCLES;
            m_tready   <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= steady || ($urandom_range(99) >= 36);
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic is_last);
        @(negedge aclk);
        while (!steady && $urandom_range(99) < 36) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= is_last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        items_sent++;
    endtask

    task automatic wait_for_drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (frames_pending != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
    endtask

    task automatic apply_setting(input logic [7:0] hf, input logic [7:0] hs,
                                 input logic [7:0] tf, input logic [7:0] ts);
        wait_for_drain();
        write_reg(CFG_HEAD_FIRST, hf);
        write_reg(CFG_HEAD_SECOND, hs);
        write_reg(CFG_TAIL_FIRST, tf);
        write_reg(CFG_TAIL_SECOND, ts);
        // an index past the last register must change nothing
        write_reg(CFG_FIRST_UNUSED + CFG_IDX_W'($urandom_range(3)), 8'($urandom));
        @(negedge aclk);
        cfg_valid       <= 1'b0;
        cur_head_first  = hf;
        cur_head_second = hs;
        cur_tail_first  = tf;
        cur_tail_second = ts;
    endtask

    task automatic send_frame(input frame_kind_t kind, input int unsigned len,
                              input bit extremes);
        logic [7:0]  fb [];
        logic [15:0] sum;
        int unsigned i;
        fb = new[len];
        for (i = 0; i < len; i++)
            fb[i] = extremes ? EXTREME_BYTES[i % 8] : 8'($urandom);
        if (kind != FR_SHORT && kind != FR_NOISE) begin
            fb[0]     = cur_head_first;
            fb[1]     = cur_head_second;
            fb[len-2] = cur_tail_first;
            fb[len-1] = cur_tail_second;
            sum = '0;
            for (i = 0; i < len - 4; i++)
                sum = sum + 16'(fb[i]);
            fb[len-4] = sum[7:0];
            fb[len-3] = sum[15:8];
            // break one or more checks; later ones now and then too
            case (kind)
                FR_BAD_HEAD: begin
                    fb[$urandom_range(1)] ^= 8'($urandom_range(255, 1));
                    if ($urandom_range(1))
                        fb[len - 1 - $urandom_range(1)] ^= 8'($urandom_range(255, 1));
                end
                FR_BAD_TAIL: begin
                    fb[len - 1 - $urandom_range(1)] ^= 8'($urandom_range(255, 1));
                    if ($urandom_range(1))
                        fb[len - 3 - $urandom_range(1)] ^= 8'($urandom_range(255, 1));
                end
                FR_BAD_SUM:
                    fb[len - 3 - $urandom_range(1)] ^= 8'($urandom_range(255, 1));
                default: ;
            endcase
        end
        for (i = 0; i < len; i++)
            push_byte(fb[i], i == len - 1);
    endtask

    task automatic random_phase(input int unsigned quota);
        int unsigned start;
        int unsigned pick;
        start = items_sent;
        while (items_sent - start < quota) begin
            pick = $urandom_range(99);
            if (pick < 2)
                send_frame(FR_GOOD, $urandom_range(300, 250), 1'b0);
            else if (pick < 62)
                send_frame(FR_GOOD, $urandom_range(30, MIN_FRAME_LEN), 1'b0);
            else if (pick < 69)
                send_frame(FR_BAD_HEAD, $urandom_range(30, MIN_FRAME_LEN), 1'b0);
            else if (pick < 76)
                send_frame(FR_BAD_TAIL, $urandom_range(30, MIN_FRAME_LEN), 1'b0);
            else if (pick < 83)
                send_frame(FR_BAD_SUM, $urandom_range(30, MIN_FRAME_LEN), 1'b0);
            else if (pick < 93)
                send_frame(FR_SHORT, $urandom_range(MIN_FRAME_LEN - 1, 1), 1'b0);
            else
                send_frame(FR_NOISE, $urandom_range(40, 1), 1'b0);
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: extreme values in a minimum-length frame, then short frames
        apply_setting(8'h00, 8'hFF, 8'hFF, 8'h00);
        send_frame(FR_GOOD, MIN_FRAME_LEN, 1'b1);
        send_frame(FR_SHORT, 1, 1'b0);
        send_frame(FR_SHORT, 4, 1'b0);

        // count saturates well before the end of this frame
        apply_setting(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_frame(FR_GOOD, 300, 1'b0);
        random_phase(PHASE_QUOTA);

        apply_setting(8'h00, 8'h00, 8'h00, 8'h00);
        steady <= 1'b1;
        random_phase(PHASE_QUOTA);
        steady <= 1'b0;

        apply_setting(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        long_stall_go <= 1'b1;
        random_phase(PHASE_QUOTA);

        apply_setting(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        random_phase(PHASE_QUOTA / 2);
        wait_for_drain();
        random_phase(PHASE_QUOTA / 2);

        apply_setting(8'h55, 8'hAA, 8'h0F, 8'hF0);
        random_phase(PHASE_QUOTA);

        apply_setting(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        random_phase(PHASE_QUOTA);

        wait_for_drain();
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
